// ----- src/idl_pkg.sv -----
// ----------------------------------------------------------------------------
// idl_pkg: shared codes for the interpolating delay line
// Operation codes and status codes used by the datapath and the checker.
// ----------------------------------------------------------------------------
package idl_pkg;

	localparam logic [1:0] FUNC_STORE_TIME  = 2'd0;
	localparam logic [1:0] FUNC_STORE_VALUE = 2'd1;
	localparam logic [1:0] FUNC_QUERY       = 2'd2;
	localparam logic [1:0] FUNC_NOP         = 2'd3;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NEG_DELAY = 2'd1;
	localparam logic [1:0] ST_BAD_EXPR  = 2'd2;
	localparam logic [1:0] ST_NOT_FOUND = 2'd3;

endpackage
// ----------------------------------------------------------------------------

// ----- src/idl_muldiv.sv -----
// ----------------------------------------------------------------------------
// idl_muldiv: serial scaled quotient
// q = (mag * part) / span, shift-add multiply (32 steps) then restoring
// divide (65 steps). Requires part < span, so q fits in 33 bits.
// ----------------------------------------------------------------------------
module idl_muldiv (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [32:0] mag,
	input  logic [31:0] part,
	input  logic [31:0] span,
	output logic        done,
	output logic [32:0] quot
);
	import idl_pkg::*;

	localparam logic [1:0] P_IDLE = 2'd0;
	localparam logic [1:0] P_MUL  = 2'd1;
	localparam logic [1:0] P_DIV  = 2'd2;

	logic [1:0]  phase_q;
	logic [6:0]  cnt_q;
	logic [64:0] acc_q;
	logic [32:0] mag_q;
	logic [31:0] mul_q;
	logic [31:0] span_q;
	logic [32:0] rem_q;
	logic [32:0] quot_q;
	logic        done_q;
	logic [32:0] rem_sh;

	assign rem_sh = {rem_q[31:0], acc_q[64]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= P_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= (phase_q == P_DIV) && (cnt_q == 7'd0);
			case (phase_q)
				P_IDLE: begin
					if (start) begin
						phase_q <= P_MUL;
						cnt_q   <= 7'd31;
					end
				end
				P_MUL: begin
					if (cnt_q == 7'd0) begin
						phase_q <= P_DIV;
						cnt_q   <= 7'd64;
					end else begin
						cnt_q <= cnt_q - 7'd1;
					end
				end
				P_DIV: begin
					if (cnt_q == 7'd0) begin
						phase_q <= P_IDLE;
					end else begin
						cnt_q <= cnt_q - 7'd1;
					end
				end
				default: phase_q <= P_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (phase_q)
			P_IDLE: begin
				if (start) begin
					acc_q  <= '0;
					mag_q  <= mag;
					mul_q  <= part;
					span_q <= span;
					rem_q  <= '0;
					quot_q <= '0;
				end
			end
			P_MUL: begin
				acc_q <= {acc_q[63:0], 1'b0} + (mul_q[31] ? {32'd0, mag_q} : 65'd0);
				mul_q <= {mul_q[30:0], 1'b0};
			end
			P_DIV: begin
				acc_q <= {acc_q[63:0], 1'b0};
				if (rem_sh >= {1'b0, span_q}) begin
					rem_q  <= rem_sh - {1'b0, span_q};
					quot_q <= {quot_q[31:0], 1'b1};
				end else begin
					rem_q  <= rem_sh;
					quot_q <= {quot_q[31:0], 1'b0};
				end
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule
// ----------------------------------------------------------------------------

// ----- src/interpolating_delay_line.sv -----
// ----------------------------------------------------------------------------
// interpolating_delay_line: variable delay with linear interpolation
// Shared time stamp ring plus one value ring per expression slot, queried at
// time_now - delay_time.
// ----------------------------------------------------------------------------
// Sequence: store beats are written when accepted; a query walks the states
//   to its result beat, through a serial multiply then divide when it
//   interpolates, and waits in S_DONE while the previous result beat is held.
// Throughput: one beat in flight; the linear search through the time ring
//   (one stamp per cycle on its read port) and the muldiv unit set the rate.
// Reset: asynchronous, clears heads, fill counts, mask and control; ring
//   contents are not cleared, fill counts keep unwritten entries unread.
module interpolating_delay_line #(
	parameter int RING_DEPTH = 1024,
	parameter int NUM_EXPRS  = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	// item channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  func,
	input  logic [2:0]  expr_id,
	input  logic [31:0] time_now,
	input  logic signed [31:0] sample_value,
	input  logic signed [31:0] delay_time,
	// result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic signed [31:0] delayed_value,
	output logic [1:0]  status,
	// mask register write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data
);
	import idl_pkg::*;

	localparam int AW  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int FW  = $clog2(RING_DEPTH + 1);
	localparam int EW  = (NUM_EXPRS > 1) ? $clog2(NUM_EXPRS) : 1;
	localparam int VD  = NUM_EXPRS * RING_DEPTH;
	localparam int VAW = (VD > 1) ? $clog2(VD) : 1;
	localparam logic [FW:0]   DEPTH_X = (FW+1)'(RING_DEPTH);
	localparam logic [FW-1:0] DEPTH_F = FW'(RING_DEPTH);
	localparam logic [AW-1:0] LAST_A  = AW'(RING_DEPTH - 1);

	// sequencer states
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_TL   = 4'd1; // newest stamp arriving
	localparam logic [3:0] S_SRCH = 4'd2; // stamp p arriving
	localparam logic [3:0] S_VFIN = 4'd3; // direct value arriving
	localparam logic [3:0] S_R0   = 4'd4; // lower value arriving
	localparam logic [3:0] S_R1   = 4'd5; // upper value arriving
	localparam logic [3:0] S_CALC = 4'd6;
	localparam logic [3:0] S_DIV  = 4'd7;
	localparam logic [3:0] S_DONE = 4'd8;

	// logical index -> physical slot
	function automatic logic [AW-1:0] ring_pos(input logic [AW-1:0] h,
			input logic [FW-1:0] f, input logic [FW-1:0] i);
		logic [FW:0] s;
		s = (FW+1)'(h) + DEPTH_X - (FW+1)'(f) + (FW+1)'(i);
		if (s >= DEPTH_X)
			s = s - DEPTH_X;
		return s[AW-1:0];
	endfunction

	// memories
	logic [31:0] time_mem [RING_DEPTH];
	logic [31:0] value_mem [VD];
	logic [AW-1:0]  t_raddr;
	logic [VAW-1:0] v_raddr;
	logic [31:0]    t_rdata;
	logic [31:0]    v_rdata;

	// ring pointers
	logic [AW-1:0] time_head_q;
	logic [FW-1:0] time_fill_q;
	logic [AW-1:0] value_head_q [NUM_EXPRS];
	logic [FW-1:0] value_fill_q [NUM_EXPRS];
	logic [7:0]    mask_q;

	// query context
	logic [3:0]  state_q;
	logic [EW-1:0] slot_q;
	logic [31:0] now_q, ts_q, prev_q, t0_q, t1_q;
	logic signed [31:0] cur_q, r0_q, r1_q, res_q;
	logic [1:0]  stat_q;
	logic [FW-1:0] p_q;
	logic        vzero_q;
	logic        need_r1_q;

	// output register
	logic        ov_q;
	logic signed [31:0] ov_data_q;
	logic [1:0]  ov_stat_q;

	logic [EW-1:0] in_slot;
	logic          in_exists;
	logic          slot_ok;
	logic          accept;
	logic [AW-1:0] vh_cur;
	logic [FW-1:0] vf_cur;
	logic [FW-1:0] v_idx;
	logic          v_fetch;
	logic signed [31:0] v_word;
	logic [FW:0]   p_next;
	logic          md_start_q;
	logic          md_done;
	logic          calc_direct;
	logic [32:0]   md_mag, md_quot;
	logic          md_neg;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_valid = ov_q;
	assign delayed_value = ov_data_q;
	assign status    = ov_stat_q;

	assign in_slot   = EW'(expr_id);
	assign in_exists = (32'(expr_id) < NUM_EXPRS);
	assign slot_ok   = in_exists && mask_q[expr_id];

	// value ring of the slot in use (input slot when idle, else latched)
	always_comb begin
		logic [EW-1:0] s;
		s = (state_q == S_IDLE) ? in_slot : slot_q;
		vh_cur = value_head_q[s];
		vf_cur = value_fill_q[s];
	end

	assign p_next = (FW+1)'(p_q) + (FW+1)'(1);
	assign v_word = vzero_q ? 32'sd0 : $signed(v_rdata);

	// read address selection and value fetch index
	always_comb begin
		logic [FW-1:0] tl_idx;
		t_raddr = '0;
		v_idx   = '0;
		v_fetch = 1'b0;
		tl_idx  = time_fill_q - FW'(1);
		case (state_q)
			S_IDLE: begin
				t_raddr = ring_pos(time_head_q, time_fill_q, tl_idx);
				v_idx   = '0;
			end
			S_TL: begin
				t_raddr = ring_pos(time_head_q, time_fill_q, '0);
				v_idx   = vf_cur - FW'(1);
			end
			S_SRCH: begin
				t_raddr = ring_pos(time_head_q, time_fill_q, p_next[FW-1:0]);
				if ($unsigned(t_rdata) == ts_q || p_q == '0)
					v_idx = p_q;
				else
					v_idx = p_q - FW'(1);
			end
			S_R0: v_idx = p_q;
			default: ;
		endcase
		v_fetch = 1'b1;
	end

	assign v_raddr = VAW'(slot_q) * VAW'(RING_DEPTH)
		+ VAW'(ring_pos(vh_cur, vf_cur, v_idx));

	// memory ports: one write, one registered read each
	always_ff @(posedge clk) begin
		if (accept && func == FUNC_STORE_TIME)
			time_mem[time_head_q] <= time_now;
		t_rdata <= time_mem[t_raddr];
	end

	always_ff @(posedge clk) begin
		if (accept && func == FUNC_STORE_VALUE && slot_ok)
			value_mem[VAW'(in_slot) * VAW'(RING_DEPTH) + VAW'(vh_cur)] <= sample_value;
		if (v_fetch)
			v_rdata <= value_mem[(state_q == S_IDLE)
				? VAW'(in_slot) * VAW'(RING_DEPTH) + VAW'(ring_pos(vh_cur, vf_cur, '0))
				: v_raddr];
	end

	// pointers and mask
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_head_q <= '0;
			time_fill_q <= '0;
			mask_q      <= '0;
			for (int i = 0; i < NUM_EXPRS; i++) begin
				value_head_q[i] <= '0;
				value_fill_q[i] <= '0;
			end
		end else begin
			if (cfg_valid)
				mask_q <= cfg_data;
			if (accept && func == FUNC_STORE_TIME) begin
				time_head_q <= (time_head_q == LAST_A) ? '0 : time_head_q + AW'(1);
				if (time_fill_q != DEPTH_F)
					time_fill_q <= time_fill_q + FW'(1);
			end
			if (accept && func == FUNC_STORE_VALUE && slot_ok) begin
				value_head_q[in_slot] <= (vh_cur == LAST_A) ? '0 : vh_cur + AW'(1);
				if (vf_cur != DEPTH_F)
					value_fill_q[in_slot] <= vf_cur + FW'(1);
			end
		end
	end

	// query sequencer
	assign md_mag = md_neg ? 33'({r0_q[31], r0_q} - {r1_q[31], r1_q})
	                       : 33'({r1_q[31], r1_q} - {r0_q[31], r0_q});
	assign md_neg = (r1_q < r0_q);

	// exact upper hit, target not above the lower stamp, or degenerate span: no division needed
	assign calc_direct = (t1_q == ts_q || t0_q >= ts_q || t1_q <= t0_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			md_start_q <= 1'b0;
		end else begin
			md_start_q <= (state_q == S_CALC) && !calc_direct;
			case (state_q)
				S_IDLE: begin
					if (accept && func == FUNC_QUERY) begin
						if (!slot_ok || delay_time < 0 || time_fill_q == '0)
							state_q <= S_DONE;
						else if (time_now <= $unsigned(delay_time))
							state_q <= S_VFIN;
						else
							state_q <= S_TL;
					end
				end
				S_TL: begin
					if (ts_q > t_rdata)
						state_q <= (vf_cur == '0) ? S_CALC : S_R0;
					else
						state_q <= S_SRCH;
				end
				S_SRCH: begin
					if (!(p_next < (FW+1)'(time_fill_q) && t_rdata < ts_q)) begin
						if (t_rdata == ts_q || p_q == '0)
							state_q <= S_VFIN;
						else
							state_q <= S_R0;
					end
				end
				S_VFIN: state_q <= S_DONE;
				S_R0:   state_q <= need_r1_q ? S_R1 : S_CALC;
				S_R1:   state_q <= S_CALC;
				S_CALC: state_q <= calc_direct ? S_DONE : S_DIV;
				S_DIV:  if (md_done) state_q <= S_DONE;
				S_DONE: if (!ov_q || out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				slot_q  <= in_slot;
				now_q   <= time_now;
				cur_q   <= sample_value;
				ts_q    <= time_now - $unsigned(delay_time);
				p_q     <= '0;
				vzero_q <= (vf_cur == '0);
				if (!slot_ok) begin
					stat_q <= ST_BAD_EXPR;
					res_q  <= 32'sd0;
				end else if (delay_time < 0) begin
					stat_q <= ST_NEG_DELAY;
					res_q  <= 32'sd0;
				end else begin
					stat_q <= ST_OK;
					res_q  <= (time_fill_q == '0) ? sample_value : 32'sd0;
				end
			end
			S_TL: begin
				t0_q      <= t_rdata;
				t1_q      <= now_q;
				r1_q      <= cur_q;
				r0_q      <= 32'sd0;
				need_r1_q <= 1'b0;
				vzero_q   <= (v_idx >= vf_cur);
			end
			S_SRCH: begin
				prev_q  <= t_rdata;
				vzero_q <= (v_idx >= vf_cur);
				if (p_next < (FW+1)'(time_fill_q) && t_rdata < ts_q) begin
					p_q <= p_next[FW-1:0];
				end else begin
					t0_q      <= prev_q;
					t1_q      <= t_rdata;
					need_r1_q <= 1'b1;
				end
			end
			S_VFIN: res_q <= v_word;
			S_R0: begin
				r0_q    <= v_word;
				vzero_q <= (v_idx >= vf_cur);
			end
			S_R1: r1_q <= v_word;
			S_CALC: begin
				if (t1_q == ts_q)
					res_q <= r1_q;
				else
					res_q <= r0_q;
			end
			S_DIV: begin
				if (md_done)
					res_q <= md_neg ? r0_q - $signed(md_quot[31:0])
					                : r0_q + $signed(md_quot[31:0]);
			end
			default: ;
		endcase
	end

	idl_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (md_start_q),
		.mag    (md_mag),
		.part   (ts_q - t0_q),
		.span   (t1_q - t0_q),
		.done   (md_done),
		.quot   (md_quot)
	);

	// result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else begin
			if (state_q == S_DONE && (!ov_q || out_ready))
				ov_q <= 1'b1;
			else if (out_ready)
				ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && (!ov_q || out_ready)) begin
			ov_data_q <= res_q;
			ov_stat_q <= stat_q;
		end
	end

endmodule
// ----------------------------------------------------------------------------

// ----- src/idl_checker.sv -----
// ----------------------------------------------------------------------------
// idl_checker: port-level checks for interpolating_delay_line
// Watches the top level's ports; attached by bind.
// ----------------------------------------------------------------------------
module idl_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [1:0]  func,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] delayed_value,
	input logic [1:0]  status
);
	import idl_pkg::*;

	// held result beat keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(delayed_value) && $stable(status))
		else $error("result beat changed while stalled");

	// error results carry zero
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> delayed_value == 32'd0)
		else $error("error result with nonzero value");

	// search always succeeds
	a_no_notfound: assert property (@(posedge clk) disable iff (!arst_n)
		!(out_valid && status == ST_NOT_FOUND))
		else $error("not-found status produced");

	// a query holds off the next beat
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && func == FUNC_QUERY |=> !in_ready)
		else $error("beat taken during a query");

endmodule

bind interpolating_delay_line idl_checker u_idl_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.func          (func),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.delayed_value (delayed_value),
	.status        (status)
);
// ----------------------------------------------------------------------------
